// ===== design/ssd_pkg.sv =====
`default_nettype none
package ssd_pkg;

    localparam logic [2:0] KIND_RESTORE  = 3'd0;
    localparam logic [2:0] KIND_REMOVE   = 3'd1;
    localparam logic [2:0] KIND_BELOW    = 3'd2;
    localparam logic [2:0] KIND_ABOVE    = 3'd3;
    localparam logic [2:0] KIND_ASSIGN   = 3'd4;
    localparam logic [2:0] KIND_CONTAINS = 3'd5;

    typedef enum logic [2:0] {
        MODE_RESTORE,
        MODE_SCAN,
        MODE_BELOW,
        MODE_ABOVE,
        MODE_ASSIGN
    } t_mode;

    typedef struct packed {
        logic  accept;
        logic  rd_probe;
        logic  sweep_start;
        t_mode mode;
        logic  sweep_rd;
        logic  sweep_wr;
        logic  remove_one;
        logic  set_fail;
        logic  commit;
        logic  load_out;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       probe_live;
        logic       count_one;
        logic       v_le_low;
        logic       v_gt_high;
        logic       v_ge_high;
        logic       v_lt_low;
        logic       v_eq_bound;
        logic       sweep_last;
        logic       out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== design/ssd_if.sv =====
`default_nettype none
interface ssd_req_if #(parameter int VALUE_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic [2:0]                    kind;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source(output valid, output kind, output value, input ready);
    modport sink(input valid, input kind, input value, output ready);
endinterface

interface ssd_rsp_if #(parameter int VALUE_WIDTH = 32, parameter int COUNT_WIDTH = 9) ();
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic                          member;
    logic [COUNT_WIDTH-1:0]        live_total;
    logic signed [VALUE_WIDTH-1:0] lower;
    logic signed [VALUE_WIDTH-1:0] upper;

    modport source(output valid, output ok, output member, output live_total,
                   output lower, output upper, input ready);
    modport sink(input valid, input ok, input member, input live_total,
                 input lower, input upper, output ready);
endinterface
`default_nettype wire

// ===== design/ssd_cfg.sv =====
`default_nettype none
module ssd_cfg #(
    parameter int VALUE_WIDTH = 32,
    parameter int DW          = 32,
    parameter int PAW         = 3
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [PAW-1:0]                 paddr,
    input  wire [DW-1:0]                  pwdata,
    output logic [DW-1:0]                 prdata,
    output logic                          pready,
    output logic signed [VALUE_WIDTH-1:0] o_dom_low,
    output logic [8:0]                    o_dom_size,
    output logic                          o_cfg_wr
);

    logic signed [VALUE_WIDTH-1:0] r_low;
    logic [8:0]                    r_size;
    logic                          r_wr;
    logic                          wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_size <= 9'd256;
            r_wr   <= 1'b0;
        end else begin
            r_wr <= wr;
            if (wr) begin
                if (paddr[PAW-1]) begin
                    r_size <= pwdata[8:0];
                end else begin
                    r_low <= VALUE_WIDTH'(pwdata);
                end
            end
        end
    end

    always_comb begin
        if (paddr[PAW-1]) begin
            prdata = DW'(r_size);
        end else begin
            prdata = DW'($unsigned(r_low));
        end
    end

    assign o_dom_low  = r_low;
    assign o_dom_size = r_size;
    assign o_cfg_wr   = r_wr;

endmodule
`default_nettype wire

// ===== design/ssd_dp.sv =====
`default_nettype none
module ssd_dp #(
    parameter int MAX_VALUES  = 256,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = 8,
    parameter int CW          = 9
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  ssd_pkg::t_cmd                 i_cmd,
    output ssd_pkg::t_stat                o_stat,
    input  wire [2:0]                     i_kind,
    input  wire signed [VALUE_WIDTH-1:0]  i_value,
    input  wire signed [VALUE_WIDTH-1:0]  i_dom_low,
    input  wire [8:0]                     i_dom_size,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic                          o_ok,
    output logic                          o_member,
    output logic [CW-1:0]                 o_total,
    output logic signed [VALUE_WIDTH-1:0] o_lower,
    output logic signed [VALUE_WIDTH-1:0] o_upper
);

    localparam int VW = VALUE_WIDTH;
    localparam int NW = (CW > 9) ? CW : 9;
    localparam int EW = ((VW + 1) > NW) ? (VW + 1) : NW;
    localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};

    // one live flag per offset
    logic r_mem [MAX_VALUES];
    logic r_rd_data;

    logic [2:0]           r_kind;
    logic signed [VW-1:0] r_val;
    logic                 r_ok;
    logic [CW-1:0]        r_count;
    logic signed [VW-1:0] r_lo;
    logic signed [VW-1:0] r_hi;
    ssd_pkg::t_mode       r_mode;
    logic [AW-1:0]        r_addr;
    logic [CW-1:0]        r_acc_cnt;
    logic [AW-1:0]        r_min_off;
    logic [AW-1:0]        r_max_off;
    logic                 r_any;
    logic                 r_out_valid;
    logic                 r_out_ok;
    logic                 r_out_member;
    logic [CW-1:0]        r_out_total;
    logic signed [VW-1:0] r_out_lo;
    logic signed [VW-1:0] r_out_hi;

    logic [NW-1:0]        size_n;
    logic [NW-1:0]        size_c;
    logic [EW-1:0]        room;
    logic [CW-1:0]        eff;
    logic signed [VW:0]   diff;
    logic                 in_range;
    logic [AW-1:0]        offset;
    logic signed [VW-1:0] sweep_val;
    logic                 new_bit;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic                 wr_bit;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 last;
    logic                 out_free;

    always_comb begin
        size_n = (i_dom_size == 9'd0) ? NW'(1) : NW'(i_dom_size);
        size_c = (size_n > NW'(MAX_VALUES)) ? NW'(MAX_VALUES) : size_n;
        room   = EW'(VMAX) - $unsigned(EW'(i_dom_low));
        if (room < (EW'(size_c) - EW'(1))) begin
            eff = CW'(room + EW'(1));
        end else begin
            eff = CW'(size_c);
        end
    end

    assign diff      = (VW+1)'(r_val) - (VW+1)'(i_dom_low);
    assign in_range  = !diff[VW] && (EW'($unsigned(diff)) < EW'(eff));
    assign offset    = AW'($unsigned(diff));
    assign sweep_val = i_dom_low + VW'(r_addr);

    always_comb begin
        case (r_mode)
            ssd_pkg::MODE_RESTORE: new_bit = CW'(r_addr) < eff;
            ssd_pkg::MODE_SCAN:    new_bit = r_rd_data;
            ssd_pkg::MODE_BELOW:   new_bit = r_rd_data && !(sweep_val < r_val);
            ssd_pkg::MODE_ABOVE:   new_bit = r_rd_data && !(sweep_val > r_val);
            ssd_pkg::MODE_ASSIGN:  new_bit = r_rd_data && (r_addr == offset);
            default:               new_bit = r_rd_data;
        endcase
    end

    assign last = (r_mode == ssd_pkg::MODE_RESTORE) ? (r_addr == AW'(MAX_VALUES - 1))
                                                    : (CW'(r_addr) == (eff - CW'(1)));

    assign wr_en   = i_cmd.remove_one | i_cmd.sweep_wr;
    assign wr_addr = i_cmd.remove_one ? offset : r_addr;
    assign wr_bit  = i_cmd.remove_one ? 1'b0 : new_bit;
    assign rd_en   = i_cmd.rd_probe | i_cmd.sweep_rd;
    assign rd_addr = i_cmd.rd_probe ? offset : r_addr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_bit;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_mode      <= ssd_pkg::MODE_RESTORE;
            r_addr      <= '0;
        end else begin
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.remove_one) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.sweep_start) begin
                r_mode <= i_cmd.mode;
                r_addr <= '0;
            end else if (i_cmd.sweep_wr) begin
                r_addr <= r_addr + AW'(1);
            end
            if (i_cmd.commit) begin
                r_count <= r_acc_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_kind;
            r_val  <= i_value;
            r_ok   <= 1'b1;
        end
        if (i_cmd.set_fail) begin
            r_ok <= 1'b0;
        end
        if (i_cmd.sweep_start) begin
            r_acc_cnt <= '0;
            r_any     <= 1'b0;
        end else if (i_cmd.sweep_wr && new_bit) begin
            r_acc_cnt <= r_acc_cnt + CW'(1);
            r_any     <= 1'b1;
            r_max_off <= r_addr;
            if (!r_any) begin
                r_min_off <= r_addr;
            end
        end
        if (i_cmd.commit) begin
            r_lo <= i_dom_low + VW'(r_min_off);
            r_hi <= i_dom_low + VW'(r_max_off);
        end
        if (i_cmd.load_out) begin
            r_out_ok     <= r_ok;
            r_out_member <= r_rd_data && in_range && (r_val >= r_lo) && (r_val <= r_hi);
            r_out_total  <= r_count;
            r_out_lo     <= r_lo;
            r_out_hi     <= r_hi;
        end
    end

    always_comb begin
        o_stat.kind       = r_kind;
        o_stat.probe_live = in_range && r_rd_data;
        o_stat.count_one  = r_count == CW'(1);
        o_stat.v_le_low   = r_val <= r_lo;
        o_stat.v_gt_high  = r_val > r_hi;
        o_stat.v_ge_high  = r_val >= r_hi;
        o_stat.v_lt_low   = r_val < r_lo;
        o_stat.v_eq_bound = (r_val == r_lo) || (r_val == r_hi);
        o_stat.sweep_last = last;
        o_stat.out_free   = out_free;
    end

    assign o_valid  = r_out_valid;
    assign o_ok     = r_out_ok;
    assign o_member = r_out_member;
    assign o_total  = r_out_total;
    assign o_lower  = r_out_lo;
    assign o_upper  = r_out_hi;

endmodule
`default_nettype wire

// ===== design/ssd_ctrl.sv =====
`default_nettype none
module ssd_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_cfg_wr,
    input  wire            i_valid,
    output logic           o_ready,
    input  ssd_pkg::t_stat i_stat,
    output ssd_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_RESTART,
        S_IDLE,
        S_PROBE,
        S_DECIDE,
        S_SWEEP_RD,
        S_SWEEP_WR,
        S_COMMIT,
        S_FINAL_RD,
        S_FINAL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_reply;
    logic   n_reply;

    assign o_ready = (r_state == S_IDLE) && !i_cfg_wr;

    always_comb begin
        o_cmd   = '0;
        o_cmd.mode = ssd_pkg::MODE_SCAN;
        n_state = r_state;
        n_reply = r_reply;
        case (r_state)
            S_RESTART: begin
                o_cmd.sweep_start = 1'b1;
                o_cmd.mode        = ssd_pkg::MODE_RESTORE;
                n_reply           = 1'b0;
                n_state           = S_SWEEP_RD;
            end
            S_IDLE: begin
                if (i_valid && !i_cfg_wr) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_PROBE;
                end
            end
            S_PROBE: begin
                o_cmd.rd_probe = 1'b1;
                n_state        = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_FINAL_RD;
                n_reply = 1'b1;
                case (i_stat.kind)
                    ssd_pkg::KIND_RESTORE: begin
                        o_cmd.sweep_start = 1'b1;
                        o_cmd.mode        = ssd_pkg::MODE_RESTORE;
                        n_state           = S_SWEEP_RD;
                    end
                    ssd_pkg::KIND_REMOVE: begin
                        if (i_stat.probe_live) begin
                            if (i_stat.count_one) begin
                                o_cmd.set_fail = 1'b1;
                            end else begin
                                o_cmd.remove_one = 1'b1;
                                if (i_stat.v_eq_bound) begin
                                    o_cmd.sweep_start = 1'b1;
                                    o_cmd.mode        = ssd_pkg::MODE_SCAN;
                                    n_state           = S_SWEEP_RD;
                                end
                            end
                        end
                    end
                    ssd_pkg::KIND_BELOW: begin
                        if (!i_stat.v_le_low) begin
                            if (i_stat.v_gt_high) begin
                                o_cmd.set_fail = 1'b1;
                            end else begin
                                o_cmd.sweep_start = 1'b1;
                                o_cmd.mode        = ssd_pkg::MODE_BELOW;
                                n_state           = S_SWEEP_RD;
                            end
                        end
                    end
                    ssd_pkg::KIND_ABOVE: begin
                        if (!i_stat.v_ge_high) begin
                            if (i_stat.v_lt_low) begin
                                o_cmd.set_fail = 1'b1;
                            end else begin
                                o_cmd.sweep_start = 1'b1;
                                o_cmd.mode        = ssd_pkg::MODE_ABOVE;
                                n_state           = S_SWEEP_RD;
                            end
                        end
                    end
                    ssd_pkg::KIND_ASSIGN: begin
                        if (!i_stat.probe_live) begin
                            o_cmd.set_fail = 1'b1;
                        end else begin
                            o_cmd.sweep_start = 1'b1;
                            o_cmd.mode        = ssd_pkg::MODE_ASSIGN;
                            n_state           = S_SWEEP_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SWEEP_RD: begin
                o_cmd.sweep_rd = 1'b1;
                n_state        = S_SWEEP_WR;
            end
            S_SWEEP_WR: begin
                o_cmd.sweep_wr = 1'b1;
                n_state        = i_stat.sweep_last ? S_COMMIT : S_SWEEP_RD;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = r_reply ? S_FINAL_RD : S_IDLE;
            end
            S_FINAL_RD: begin
                o_cmd.rd_probe = 1'b1;
                n_state        = S_FINAL;
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_RESTART;
            end
        endcase
        if (i_cfg_wr) begin
            n_state = S_RESTART;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RESTART;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_reply <= n_reply;
        end
    end

endmodule
`default_nettype wire

// ===== design/sparse_set_domain_core.sv =====
// Sparse-set integer domain.
// Requests arrive on i_req (kind, value) and each one returns exactly one
// word on o_rsp (ok, member, live_total, lower, upper), unless a register
// write restarts the domain first. Both channels use a valid/ready
// handshake; the domain range is set over the APB port, and any register
// write restores the full domain.
// Live flags sit in a single-port-write, single-port-read memory of
// MAX_VALUES bits; every request costs a probe read and a final read of its
// operand. Restore, threshold removal, assign and a remove that hits a bound
// also sweep the memory, reading then writing each entry, and end with a
// commit step: restore walks all MAX_VALUES entries, the others the
// effective domain size.
// After reset a restore runs with i_req.ready low; after a register write
// ready stays low until the restore that it starts is done.
// The result sits in an output register; a stalled receiver holds it there
// and the next request is taken, but its result waits until the register
// frees.
`default_nettype none
module sparse_set_domain_core #(
    parameter int MAX_VALUES  = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    ssd_req_if.sink                              i_req,
    ssd_rsp_if.source                            o_rsp,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire [((VALUE_WIDTH > 32) ? 4 : 3)-1:0] paddr,
    input  wire [((VALUE_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic                                 pready
);

    localparam int DW  = (VALUE_WIDTH > 32) ? 64 : 32;
    localparam int PAW = (VALUE_WIDTH > 32) ? 4 : 3;
    localparam int AW  = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CW  = $clog2(MAX_VALUES + 1);

    logic signed [VALUE_WIDTH-1:0] dom_low;
    logic [8:0]                    dom_size;
    logic                          cfg_wr;
    ssd_pkg::t_cmd                 cmd;
    ssd_pkg::t_stat                stat;

    ssd_cfg #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .DW         (DW),
        .PAW        (PAW)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_dom_low (dom_low),
        .o_dom_size(dom_size),
        .o_cfg_wr  (cfg_wr)
    );

    ssd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg_wr(cfg_wr),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ssd_dp #(
        .MAX_VALUES (MAX_VALUES),
        .VALUE_WIDTH(VALUE_WIDTH),
        .AW         (AW),
        .CW         (CW)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_kind    (i_req.kind),
        .i_value   (i_req.value),
        .i_dom_low (dom_low),
        .i_dom_size(dom_size),
        .o_valid   (o_rsp.valid),
        .i_ready   (o_rsp.ready),
        .o_ok      (o_rsp.ok),
        .o_member  (o_rsp.member),
        .o_total   (o_rsp.live_total),
        .o_lower   (o_rsp.lower),
        .o_upper   (o_rsp.upper)
    );

endmodule
`default_nettype wire
